@@ rtl/core/trs_to_affine_matrix_macros.svh @@
// Assertion helpers for the TRS matrix block.
// Each helper expects clk and rst in scope.
`ifndef TRS_TO_AFFINE_MATRIX_MACROS_SVH
`define TRS_TO_AFFINE_MATRIX_MACROS_SVH
`ifndef SYNTH
`define TRSM_ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("trsm same-cycle check failed");
`define TRSM_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("trsm next-cycle check failed");
`else
`define TRSM_ASSERT_SAME(lbl, ant, cons)
`define TRSM_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

@@ rtl/core/trsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package trsm_pkg;

  localparam int QW    = 16;  // quaternion and scale width
  localparam int MW    = 32;  // Q16.16 width
  localparam int AXW   = 30;  // rotated axes, Q.24
  localparam int AZW   = 35;  // X cross Y, Q.24
  localparam int BYW   = 40;  // rebuilt Y, Q.24
  localparam int NST   = 8;   // pipeline depth

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic signed [QW-1:0] scale_x;
    logic signed [QW-1:0] scale_y;
    logic signed [QW-1:0] scale_z;
    logic signed [MW-1:0] move_x;
    logic signed [MW-1:0] move_y;
    logic signed [MW-1:0] move_z;
  } in_item_t;

  typedef struct packed {
    logic signed [MW-1:0] col0_x;
    logic signed [MW-1:0] col0_y;
    logic signed [MW-1:0] col0_z;
    logic signed [MW-1:0] col1_x;
    logic signed [MW-1:0] col1_y;
    logic signed [MW-1:0] col1_z;
    logic signed [MW-1:0] col2_x;
    logic signed [MW-1:0] col2_y;
    logic signed [MW-1:0] col2_z;
    logic signed [MW-1:0] pos_x;
    logic signed [MW-1:0] pos_y;
    logic signed [MW-1:0] pos_z;
  } out_item_t;

  typedef struct packed {
    logic signed [QW-1:0] sc_x;
    logic signed [QW-1:0] sc_y;
    logic signed [QW-1:0] sc_z;
    logic signed [MW-1:0] mv_x;
    logic signed [MW-1:0] mv_y;
    logic signed [MW-1:0] mv_z;
  } side_t;

endpackage
`default_nettype wire

@@ rtl/core/trsm_scale_sat.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Q.24 entry times Q8.8 scale, floored to Q16.16 and saturated. Two stages.
module trsm_scale_sat
  import trsm_pkg::*;
#(
  parameter int W = AXW
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [W-1:0]  val,
  input  wire logic signed [QW-1:0] sc,
  output logic signed [MW-1:0]      res
);

  localparam int PW = W + QW;
  localparam logic signed [PW-1:0] HI = PW'(32'sh7fffffff);
  localparam logic signed [PW-1:0] LO = -HI - PW'(1);

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shr;

  assign shr = prod >>> 16;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= val * sc;
      if (shr > HI) begin
        res <= HI[MW-1:0];
      end else if (shr < LO) begin
        res <= LO[MW-1:0];
      end else begin
        res <= shr[MW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/trs_to_affine_matrix.sv @@
`timescale 1ns / 1ps
`default_nettype none
// TRS to affine matrix. Each item carries a Q2.14 quaternion, a Q8.8 scale
// per axis and a Q16.16 translation; the result item holds the three scaled
// basis columns and the translation, all Q16.16 (bottom row 0,0,0,1 implied).
// The quaternion is not normalized. X and Y axes come from the quaternion
// polynomial, Z = X x Y, Y is rebuilt as Z x X, every floor rounds toward
// minus infinity and outputs saturate to 32 bits. The pipeline is eight
// stages deep: an item is accepted every cycle unless the pipe is stalled.
// One stall from the sink freezes the whole pipe; src_stall is high only
// while a finished item sits at the output and dst_stall is high.
`include "trs_to_affine_matrix_macros.svh"
module trs_to_affine_matrix
  import trsm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      src_valid,
  output logic           src_stall,
  input  wire in_item_t  src_item,
  output logic           dst_valid,
  input  wire logic      dst_stall,
  output out_item_t      dst_item
);

  logic           en;
  logic [NST-1:0] vld;

  // stage 1: quaternion products
  logic signed [31:0] p_yy, p_zz, p_wz, p_xy, p_xz, p_wy, p_xx, p_wx, p_yz;
  side_t side1, side2, side3, side4, side5, side6;
  logic signed [MW-1:0] mv7 [3];
  logic signed [MW-1:0] mv8 [3];

  // stage 2: rotated X and Y axes
  logic signed [AXW-1:0] ax2 [3];
  logic signed [AXW-1:0] ay2 [3];
  logic signed [34:0]    sum_a [6];

  // stage 3: first cross products
  logic signed [59:0]    m3 [6];
  logic signed [AXW-1:0] ax3 [3];

  // stage 4: Z axis
  logic signed [AZW-1:0] az4 [3];
  logic signed [AXW-1:0] ax4 [3];
  logic signed [60:0]    dz [3];

  // stage 5: split partial products for Z x X
  logic signed [47:0]    ph5 [6];
  logic signed [47:0]    pl5 [6];
  logic signed [AZW-1:0] az5 [3];
  logic signed [AXW-1:0] ax5 [3];

  // stage 6: rebuilt Y
  logic signed [BYW-1:0] by6 [3];
  logic signed [AZW-1:0] az6 [3];
  logic signed [AXW-1:0] ax6 [3];
  logic signed [65:0]    pf [6];
  logic signed [65:0]    dy [3];

  logic signed [MW-1:0]  c0 [3];
  logic signed [MW-1:0]  c1 [3];
  logic signed [MW-1:0]  c2 [3];

  assign en        = !vld[NST-1] || !dst_stall;
  assign src_stall = !en;
  assign dst_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], src_valid};
    end
  end

  // Axis sums in Q.28 before the floor to Q.24.
  always_comb begin
    sum_a[0] = (35'sd1 <<< 28) - ((35'(p_yy) + 35'(p_zz)) <<< 1);
    sum_a[1] = (35'(p_wz) + 35'(p_xy)) <<< 1;
    sum_a[2] = (35'(p_xz) - 35'(p_wy)) <<< 1;
    sum_a[3] = (35'(p_xy) - 35'(p_wz)) <<< 1;
    sum_a[4] = (35'sd1 <<< 28) - ((35'(p_xx) + 35'(p_zz)) <<< 1);
    sum_a[5] = (35'(p_wx) + 35'(p_yz)) <<< 1;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dz[i] = 61'(m3[2*i]) - 61'(m3[2*i+1]);
    end
  end

  // Recombine the split halves of each Z x X product.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      pf[k] = (66'(ph5[k]) <<< 17) + 66'(pl5[k]);
    end
    for (int i = 0; i < 3; i++) begin
      dy[i] = pf[2*i] - pf[2*i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_yy <= src_item.quat_y * src_item.quat_y;
      p_zz <= src_item.quat_z * src_item.quat_z;
      p_wz <= src_item.quat_w * src_item.quat_z;
      p_xy <= src_item.quat_x * src_item.quat_y;
      p_xz <= src_item.quat_x * src_item.quat_z;
      p_wy <= src_item.quat_w * src_item.quat_y;
      p_xx <= src_item.quat_x * src_item.quat_x;
      p_wx <= src_item.quat_w * src_item.quat_x;
      p_yz <= src_item.quat_y * src_item.quat_z;
      side1 <= '{sc_x: src_item.scale_x, sc_y: src_item.scale_y,
                 sc_z: src_item.scale_z, mv_x: src_item.move_x,
                 mv_y: src_item.move_y, mv_z: src_item.move_z};

      for (int i = 0; i < 3; i++) begin
        ax2[i] <= sum_a[i][33:4];
        ay2[i] <= sum_a[i+3][33:4];
      end
      side2 <= side1;

      // X cross Y
      m3[0] <= ax2[1] * ay2[2];
      m3[1] <= ax2[2] * ay2[1];
      m3[2] <= ax2[2] * ay2[0];
      m3[3] <= ax2[0] * ay2[2];
      m3[4] <= ax2[0] * ay2[1];
      m3[5] <= ax2[1] * ay2[0];
      ax3   <= ax2;
      side3 <= side2;

      for (int i = 0; i < 3; i++) begin
        az4[i] <= dz[i][58:24];
      end
      ax4   <= ax3;
      side4 <= side3;

      // Z cross X, Z split into a signed high part and an unsigned low part
      ph5[0] <= $signed(az4[1][AZW-1:17]) * ax4[2];
      pl5[0] <= $signed({1'b0, az4[1][16:0]}) * ax4[2];
      ph5[1] <= $signed(az4[2][AZW-1:17]) * ax4[1];
      pl5[1] <= $signed({1'b0, az4[2][16:0]}) * ax4[1];
      ph5[2] <= $signed(az4[2][AZW-1:17]) * ax4[0];
      pl5[2] <= $signed({1'b0, az4[2][16:0]}) * ax4[0];
      ph5[3] <= $signed(az4[0][AZW-1:17]) * ax4[2];
      pl5[3] <= $signed({1'b0, az4[0][16:0]}) * ax4[2];
      ph5[4] <= $signed(az4[0][AZW-1:17]) * ax4[1];
      pl5[4] <= $signed({1'b0, az4[0][16:0]}) * ax4[1];
      ph5[5] <= $signed(az4[1][AZW-1:17]) * ax4[0];
      pl5[5] <= $signed({1'b0, az4[1][16:0]}) * ax4[0];
      az5   <= az4;
      ax5   <= ax4;
      side5 <= side4;

      for (int i = 0; i < 3; i++) begin
        by6[i] <= dy[i][63:24];
      end
      az6   <= az5;
      ax6   <= ax5;
      side6 <= side5;

      mv7[0] <= side6.mv_x;
      mv7[1] <= side6.mv_y;
      mv7[2] <= side6.mv_z;
      mv8    <= mv7;
    end
  end

  // stages 7 and 8: scale, floor and saturate
  for (genvar i = 0; i < 3; i++) begin : g_col
    trsm_scale_sat #(.W(AXW)) u_c0 (
      .clk(clk), .en(en), .val(ax6[i]), .sc(side6.sc_x), .res(c0[i])
    );
    trsm_scale_sat #(.W(BYW)) u_c1 (
      .clk(clk), .en(en), .val(by6[i]), .sc(side6.sc_y), .res(c1[i])
    );
    trsm_scale_sat #(.W(AZW)) u_c2 (
      .clk(clk), .en(en), .val(az6[i]), .sc(side6.sc_z), .res(c2[i])
    );
  end

  always_comb begin
    dst_item.col0_x = c0[0];
    dst_item.col0_y = c0[1];
    dst_item.col0_z = c0[2];
    dst_item.col1_x = c1[0];
    dst_item.col1_y = c1[1];
    dst_item.col1_z = c1[2];
    dst_item.col2_x = c2[0];
    dst_item.col2_y = c2[1];
    dst_item.col2_z = c2[2];
    dst_item.pos_x  = mv8[0];
    dst_item.pos_y  = mv8[1];
    dst_item.pos_z  = mv8[2];
  end

  // an accepted item always lands in the first stage
  `TRSM_ASSERT_NEXT(a_accept_enters, src_valid && !src_stall, vld[0])
  // a frozen pipe keeps its occupancy
  `TRSM_ASSERT_NEXT(a_freeze_holds, !en, vld == $past(vld))
  // input is only held back by a waiting result
  `TRSM_ASSERT_SAME(a_stall_cause, src_stall, dst_valid && dst_stall)

endmodule
`default_nettype wire
